[hdl/svp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and constants for the version string parser.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int unsigned PartWidth = 31;
    localparam int unsigned CharWidth = 8;

    localparam logic [CharWidth-1:0] CHAR_V     = 8'h76; // 'v'
    localparam logic [CharWidth-1:0] CHAR_DASH  = 8'h2D; // '-'
    localparam logic [CharWidth-1:0] CHAR_DOT   = 8'h2E; // '.'
    localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39; // '9'

    // Index of the run currently being read.
    localparam logic [1:0] PART_MAJOR = 2'd0;
    localparam logic [1:0] PART_MINOR = 2'd1;
    localparam logic [1:0] PART_PATCH = 2'd2;

    typedef struct packed {
        logic [CharWidth-1:0] char_byte;
        logic                 end_mark;
    } svp_in_t;

    typedef struct packed {
        logic                 is_valid;
        logic [PartWidth-1:0] major_part;
        logic [PartWidth-1:0] minor_part;
        logic [PartWidth-1:0] patch_part;
    } svp_out_t;

endpackage

[hdl/semantic_version_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semantic_version_parser
// Parses a major.minor.patch version string presented one byte per item.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle unless an end marker is held
// back, each item carrying either one byte of the string or the end marker.
// Every item is first held in an input register; a byte item is processed in
// the following cycle, where it updates the parse state through one
// multiply-by-ten, add and range check; that step sets the clock rate. The
// end marker loads one result item into the result register once it is free,
// and the parse state returns to its start condition for the next string. A
// result that is not taken holds the next end marker in the input register,
// and with it every later item; byte items ahead of the marker keep flowing.
module semantic_version_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  svp_pkg::svp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output svp_pkg::svp_out_t m_data
);
    import svp_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_PARSE,
        PH_TRAIL,
        PH_IGNORE_OK,
        PH_INVALID
    } phase_t;

    localparam int unsigned ProdWidth = PartWidth + 4;

    // Input register.
    logic     in_valid_reg;
    svp_in_t  in_data_reg;

    // Parse state.
    phase_t                phase_reg, phase_next;
    logic [1:0]            part_reg, part_next;
    logic [PartWidth-1:0]  acc_reg, acc_next;
    logic                  digits_reg, digits_next;
    logic [PartWidth-1:0]  major_reg, major_next;
    logic [PartWidth-1:0]  minor_reg, minor_next;

    // Result register.
    logic      m_valid_reg;
    svp_out_t  m_data_reg, m_data_next;

    logic                  proc;
    logic                  is_end;
    logic                  is_digit;
    logic [ProdWidth-1:0]  acc_times_ten;
    logic                  end_valid;
    logic [CharWidth-1:0]  c;

    assign c      = in_data_reg.char_byte;
    assign is_end = in_data_reg.end_mark;

    // An end item can only move on when the result register is free.
    assign proc    = in_valid_reg && (!is_end || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    assign is_digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {{(ProdWidth-4){1'b0}}, c[3:0]};

    always_comb begin
        if (phase_reg == PH_PARSE) begin
            end_valid = (part_reg == PART_PATCH) && digits_reg;
        end else begin
            end_valid = (phase_reg == PH_TRAIL) || (phase_reg == PH_IGNORE_OK);
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        part_next   = part_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        m_data_next.is_valid   = end_valid;
        m_data_next.major_part = end_valid ? major_reg : '0;
        m_data_next.minor_part = end_valid ? minor_reg : '0;
        m_data_next.patch_part = end_valid ? acc_reg : '0;

        if (is_end) begin
            phase_next  = PH_START;
            part_next   = PART_MAJOR;
            acc_next    = '0;
            digits_next = 1'b0;
            major_next  = '0;
            minor_next  = '0;
        end else begin
            case (phase_reg)
                PH_START,
                PH_PARSE: begin
                    if (phase_reg == PH_START && c == CHAR_V) begin
                        // A leading 'v' is dropped.
                        phase_next = PH_PARSE;
                    end else if (is_digit) begin
                        if (acc_times_ten[ProdWidth-1:PartWidth] != '0) begin
                            phase_next = PH_INVALID;
                        end else begin
                            phase_next  = PH_PARSE;
                            acc_next    = acc_times_ten[PartWidth-1:0];
                            digits_next = 1'b1;
                        end
                    end else if (c == CHAR_DOT) begin
                        if (!digits_reg) begin
                            phase_next = PH_INVALID;
                        end else if (part_reg == PART_MAJOR) begin
                            phase_next  = PH_PARSE;
                            major_next  = acc_reg;
                            part_next   = PART_MINOR;
                            acc_next    = '0;
                            digits_next = 1'b0;
                        end else if (part_reg == PART_MINOR) begin
                            phase_next  = PH_PARSE;
                            minor_next  = acc_reg;
                            part_next   = PART_PATCH;
                            acc_next    = '0;
                            digits_next = 1'b0;
                        end else begin
                            phase_next = PH_TRAIL;
                        end
                    end else if (c == CHAR_DASH) begin
                        phase_next = (part_reg == PART_PATCH && digits_reg)
                                   ? PH_IGNORE_OK : PH_INVALID;
                    end else begin
                        phase_next = PH_INVALID;
                    end
                end
                PH_TRAIL: begin
                    phase_next = (c == CHAR_DASH) ? PH_IGNORE_OK : PH_INVALID;
                end
                PH_IGNORE_OK,
                PH_INVALID: begin
                    phase_next = phase_reg;
                end
                default: begin
                    phase_next = PH_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_START;
            part_reg     <= PART_MAJOR;
            acc_reg      <= '0;
            digits_reg   <= 1'b0;
            major_reg    <= '0;
            minor_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc) begin
                phase_reg  <= phase_next;
                part_reg   <= part_next;
                acc_reg    <= acc_next;
                digits_reg <= digits_next;
                major_reg  <= major_next;
                minor_reg  <= minor_next;
            end
            if (proc && is_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc && is_end) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An invalid result carries zero in every part.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_valid |->
            (m_data.major_part == '0 && m_data.minor_part == '0 &&
             m_data.patch_part == '0))
        else $error("invalid result with non-zero parts");

    // The run index never goes past the patch run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        part_reg != 2'd3)
        else $error("run index out of range");

    // An empty run holds a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !digits_reg |-> acc_reg == '0)
        else $error("accumulator non-zero without digits");

    // The trailing dot is only reached after a non-empty patch run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TRAIL |-> (part_reg == PART_PATCH && digits_reg))
        else $error("trailing dot state reached too early");

    // The end item leaves the parser in its start condition.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && is_end |=> (phase_reg == PH_START && acc_reg == '0 &&
                            part_reg == PART_MAJOR && m_valid_reg))
        else $error("parser not restarted after end item");

endmodule

[bench/version_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_checker
// Watches both channels of the version string parser, predicts every result
// item from the accepted input items and compares it field by field.
// ----------------------------------------------------------------------------
module version_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  svp_pkg::svp_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  svp_pkg::svp_out_t m_data,
    output int                fail_count,
    output int                pending_count
);
    import svp_pkg::*;

    localparam logic [63:0] RUN_LIMIT = 64'h7FFF_FFFF;
    localparam int          REPORT_CAP = 20;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_RUNS,
        SCAN_TRAIL_DOT,
        SCAN_TAIL_OK,
        SCAN_BAD
    } scan_phase_t;

    scan_phase_t          scan_phase;
    logic [1:0]           run_sel;
    logic [PartWidth-1:0] run_value;
    logic                 run_has_digit;
    logic [PartWidth-1:0] major_hold;
    logic [PartWidth-1:0] minor_hold;

    svp_out_t expected_versions[$];
    int       result_index;

    task automatic clear_scan();
        scan_phase    = SCAN_START;
        run_sel       = PART_MAJOR;
        run_value     = '0;
        run_has_digit = 1'b0;
        major_hold    = '0;
        minor_hold    = '0;
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
        result_index  = 0;
        clear_scan();
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < REPORT_CAP)
            $display("%0t ns: result %0d, %s: got %0d, expected %0d",
                     $time, result_index, what, got, want);
        fail_count++;
    endtask

    task automatic scan_char(input logic [CharWidth-1:0] c);
        logic [63:0] grown;
        if (scan_phase == SCAN_BAD || scan_phase == SCAN_TAIL_OK)
            return;
        if (scan_phase == SCAN_START) begin
            scan_phase = SCAN_RUNS;
            // A leading 'v' is dropped, but only in the very first byte.
            if (c == CHAR_V)
                return;
        end
        if (scan_phase == SCAN_TRAIL_DOT) begin
            scan_phase = (c == CHAR_DASH) ? SCAN_TAIL_OK : SCAN_BAD;
            return;
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            grown = {33'd0, run_value} * 64'd10 + {56'd0, c - CHAR_ZERO};
            if (grown > RUN_LIMIT) begin
                scan_phase = SCAN_BAD;
            end else begin
                run_value     = grown[PartWidth-1:0];
                run_has_digit = 1'b1;
            end
        end else if (c == CHAR_DOT) begin
            if (!run_has_digit) begin
                scan_phase = SCAN_BAD;
            end else if (run_sel == PART_MAJOR) begin
                major_hold    = run_value;
                run_sel       = PART_MINOR;
                run_value     = '0;
                run_has_digit = 1'b0;
            end else if (run_sel == PART_MINOR) begin
                minor_hold    = run_value;
                run_sel       = PART_PATCH;
                run_value     = '0;
                run_has_digit = 1'b0;
            end else begin
                scan_phase = SCAN_TRAIL_DOT;
            end
        end else if (c == CHAR_DASH) begin
            scan_phase = (run_sel == PART_PATCH && run_has_digit) ? SCAN_TAIL_OK : SCAN_BAD;
        end else begin
            scan_phase = SCAN_BAD;
        end
    endtask

    task automatic close_version();
        svp_out_t ver;
        logic     ok;
        if (scan_phase == SCAN_RUNS)
            ok = (run_sel == PART_PATCH) && run_has_digit;
        else
            ok = (scan_phase == SCAN_TRAIL_DOT) || (scan_phase == SCAN_TAIL_OK);
        ver.is_valid   = ok;
        ver.major_part = ok ? major_hold : '0;
        ver.minor_part = ok ? minor_hold : '0;
        ver.patch_part = ok ? run_value : '0;
        expected_versions.push_back(ver);
        clear_scan();
    endtask

    always @(posedge aclk) begin
        svp_out_t want;
        if (!aresetn) begin
            expected_versions.delete();
            clear_scan();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_versions.size() == 0) begin
                    report_mismatch("no result was due", 32'd1, 32'd0);
                end else begin
                    want = expected_versions.pop_front();
                    if (m_data.is_valid !== want.is_valid)
                        report_mismatch("is_valid", {31'd0, m_data.is_valid},
                                        {31'd0, want.is_valid});
                    if (m_data.major_part !== want.major_part)
                        report_mismatch("major_part", {1'b0, m_data.major_part},
                                        {1'b0, want.major_part});
                    if (m_data.minor_part !== want.minor_part)
                        report_mismatch("minor_part", {1'b0, m_data.minor_part},
                                        {1'b0, want.minor_part});
                    if (m_data.patch_part !== want.patch_part)
                        report_mismatch("patch_part", {1'b0, m_data.patch_part},
                                        {1'b0, want.patch_part});
                end
                result_index++;
            end
            if (s_valid && s_ready) begin
                if (s_data.end_mark)
                    close_version();
                else
                    scan_char(s_data.char_byte);
            end
        end
        pending_count <= expected_versions.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives version strings into the parser with random gaps on both channels
// and gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
// A few directed strings come first, then random strings: most are well
// formed with random numbers, the rest are mutated, have a random number of
// runs or are plain noise. Once the receiver holds off for a long stretch
// while strings keep coming, and once the sender waits for every result.
module tb;
    import svp_pkg::*;

    localparam int RANDOM_ITEMS   = 600;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    svp_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    svp_out_t m_data;

    int fail_count;
    int pending_count;
    int item_count = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    bit burst = 1'b0;

    logic [7:0] text_buf[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    semantic_version_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    version_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic send_item(input logic [7:0] c, input logic last);
        svp_in_t item;
        item.char_byte = c;
        item.end_mark  = last;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        item_count++;
    endtask

    task automatic rest(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_text();
        bit quiet;
        foreach (text_buf[i]) begin
            quiet = burst || (hold_req && !hold_done);
            send_item(text_buf[i], 1'b0);
            rest(quiet ? 0 : pick_gap());
        end
        quiet = burst || (hold_req && !hold_done);
        // The byte of an end item carries no meaning, so it is random.
        send_item(8'($urandom_range(0, 255)), 1'b1);
        rest(quiet ? 0 : pick_gap());
    endtask

    task automatic load_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic append_number(input longint unsigned val);
        logic [7:0] digits[$];
        int         zeros;
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        repeat (zeros) text_buf.push_back(CHAR_ZERO);
        do begin
            digits.push_front(CHAR_ZERO + 8'(val % 10));
            val = val / 10;
        end while (val != 0);
        foreach (digits[i]) text_buf.push_back(digits[i]);
    endtask

    function automatic longint unsigned pick_run_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 65535);
        if (r < 80)
            return {33'd0, 31'($urandom)};
        if (r < 92) begin
            // Around the largest value a run may hold.
            if ($urandom_range(0, 1) == 0)
                return 64'd2147483647 - $urandom_range(0, 3);
            return 64'd2147483647 + $urandom_range(1, 3);
        end
        return {32'd0, $urandom} * 64'd10 + $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] pick_odd_byte();
        case ($urandom_range(0, 4))
            0: return CHAR_DOT;
            1: return CHAR_DASH;
            2: return CHAR_V;
            3: return CHAR_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_string();
        int kind;
        int runs;
        int idx;
        kind = $urandom_range(0, 99);
        text_buf.delete();
        if (kind < 85) begin
            if ($urandom_range(0, 9) < 3)
                text_buf.push_back(CHAR_V);
            for (int i = 0; i < 3; i++) begin
                if (i > 0)
                    text_buf.push_back(CHAR_DOT);
                append_number(pick_run_value());
            end
            if ($urandom_range(0, 4) == 0)
                text_buf.push_back(CHAR_DOT);
            if ($urandom_range(0, 3) == 0) begin
                text_buf.push_back(CHAR_DASH);
                repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
            end
            // Broken variants of a well formed string.
            if (kind >= 70) begin
                idx = $urandom_range(0, text_buf.size() - 1);
                if ($urandom_range(0, 3) == 0)
                    text_buf.delete(idx);
                else
                    text_buf[idx] = pick_odd_byte();
            end
        end else if (kind < 95) begin
            runs = $urandom_range(1, 5);
            for (int i = 0; i < runs; i++) begin
                if (i > 0)
                    text_buf.push_back(CHAR_DOT);
                if ($urandom_range(0, 9) >= 3)
                    append_number($urandom_range(0, 999));
            end
        end else begin
            repeat ($urandom_range(0, 6)) text_buf.push_back(pick_odd_byte());
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int calm;
        int r;
        calm = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            r = $urandom_range(0, 99);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (calm > 0) begin
                calm--;
                m_ready <= 1'b1;
            end else if (r < 3) begin
                calm = $urandom_range(50, 150);
                m_ready <= 1'b1;
            end else if (r < 20) begin
                m_ready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 2))
                    @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int  random_start;
        bit  paused;
        paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed strings: empty, dash after the leading 'v', 'v' out of
        // place with too few runs, trailing dot then dash and a tail, a
        // foreign byte, and a run that is too large.
        load_text("");
        send_text();
        load_text("v-");
        send_text();
        load_text("1v.2");
        send_text();
        load_text("1.2.3.-");
        text_buf.push_back(8'h00);
        send_text();
        text_buf.delete();
        text_buf.push_back(8'hFF);
        send_text();
        load_text("3000000000");
        send_text();

        random_start = item_count;
        while (item_count - random_start < RANDOM_ITEMS) begin
            if (!paused && item_count - random_start >= RANDOM_ITEMS / 4) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_count != 0);
            end
            if (!hold_req && item_count - random_start >= RANDOM_ITEMS / 2)
                hold_req = 1'b1;
            burst = ($urandom_range(0, 3) == 0);
            build_string();
            send_text();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hdl/svp_pkg.sv
hdl/semantic_version_parser.sv
bench/version_checker.sv
bench/tb.sv
